// File: hdl/best_fit_block_allocator_assert.svh
// Assertion macros for the best-fit block allocator checker.
// Depends on nothing; included by the checker file.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
// implication checked every clock, off during reset
`define BFA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// next-cycle implication
`define BFA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

// File: hdl/bfa_pkg.sv
// Package for the best-fit block allocator: sizes, status codes, entry type.
// Depends on nothing.
package bfa_pkg;
	localparam int MAX_BLOCKS = 64;
	localparam int ADDR_BITS = 16;
	localparam int IDX_BITS = $clog2(MAX_BLOCKS);
	localparam int CNT_BITS = 7;
	localparam int STAMP_BITS = 16;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_NO_FIT = 3'd1;
	localparam logic [2:0] ST_BAD_ADDR = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_ZERO = 3'd4;

	typedef struct packed {
		logic used;
		logic [ADDR_BITS-1:0] start;
		logic [ADDR_BITS-1:0] size;
		logic [STAMP_BITS-1:0] stamp;
	} entry_t;
endpackage

// File: hdl/best_fit_block_allocator.sv
// Best-fit block allocator with coalescing; top level with its sequencer.
// Depends on bfa_pkg.
//
// Usage: in_valid/in_stall carry one request item (kind, request_size,
// block_address); out_valid/out_stall carry one result item per request.
// The block table lives in a 64-entry memory with one read and one write
// port, read data registered; valid bits sit in flip-flops.
// Each request walks the table up to three times: a search pass (best fit
// or address match), a neighbour pass on free, and a statistics pass.
// Each pass reads every table entry in turn through the registered read
// port. An allocate that splits a block writes two entries, an exact fit
// or a free writes one, a failed search or an unknown address writes none,
// and a zero size skips the search. in_stall stays high until the result
// has left the output register, so no new item is taken while one is in
// flight. After reset the S_INIT state writes entry 0 as a free block of
// 4096 units, and pool_size_we rebuilds the table while idle (valid bits
// cleared, entry 0 written). A stalled result holds in the output register.
module best_fit_block_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pool_size_we,
	input  logic [15:0] pool_size_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [15:0] request_size,
	input  logic [15:0] block_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [15:0] granted_address,
	output logic [15:0] smallest_free,
	output logic [15:0] largest_free,
	output logic [6:0]  free_count,
	output logic [15:0] smallest_used,
	output logic [15:0] largest_used,
	output logic [6:0]  used_count
);
	localparam int IB = bfa_pkg::IDX_BITS;
	localparam int AB = bfa_pkg::ADDR_BITS;
	localparam int SB = bfa_pkg::STAMP_BITS;
	localparam int CB = bfa_pkg::CNT_BITS;
	localparam logic [IB:0] LAST = (IB+1)'(bfa_pkg::MAX_BLOCKS - 1);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_NBR = 4'd3;
	localparam logic [3:0] S_RDH = 4'd4;
	localparam logic [3:0] S_WR1 = 4'd5;
	localparam logic [3:0] S_WR2 = 4'd6;
	localparam logic [3:0] S_STAT = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;
	localparam logic [3:0] S_INIT = 4'd9;

	logic [3:0] state_q;
	bfa_pkg::entry_t mem [bfa_pkg::MAX_BLOCKS];
	logic [bfa_pkg::MAX_BLOCKS-1:0] valid_q;
	logic [15:0] pool_q;
	logic [SB-1:0] stamp_q;

	logic [IB:0] rd_cnt_q;
	logic [IB-1:0] rd_idx_d1_q;
	logic rd_live_q;
	bfa_pkg::entry_t rdata_q;

	logic kind_q;
	logic [AB-1:0] req_q, addr_q;
	logic best_ok_q, empty_ok_q, bef_ok_q, aft_ok_q;
	logic [IB-1:0] best_q, empty_q, bef_q, aft_q;
	bfa_pkg::entry_t best_e_q;
	logic [AB-1:0] new_start_q, new_end_q;
	logic [2:0] st_q;
	logic [AB-1:0] grant_q;

	logic [AB-1:0] sf_q, lf_q, su_q, lu_q;
	logic [CB-1:0] fc_q, uc_q;
	logic ov_q;

	logic we;
	logic [IB-1:0] wa;
	bfa_pkg::entry_t wd;
	logic [IB-1:0] ra;
	logic last_rd;
	logic rv;
	logic [SB-1:0] age_r, age_b;

	assign in_stall = (state_q != S_IDLE) || ov_q || pool_size_we;
	assign out_valid = ov_q;
	assign ra = (state_q == S_RDH) ? '0 : rd_cnt_q[IB-1:0];
	assign last_rd = (rd_cnt_q == LAST);
	assign rv = rd_live_q && valid_q[rd_idx_d1_q];
	assign age_r = stamp_q - rdata_q.stamp;
	assign age_b = stamp_q - best_e_q.stamp;

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[ra];
		rd_idx_d1_q <= ra;
	end

	// write port select
	always_comb begin
		we = 1'b0;
		wa = '0;
		wd = '0;
		if (state_q == S_INIT) begin
			we = 1'b1;
			wd.size = pool_q;
		end else if (pool_size_we && state_q == S_IDLE) begin
			we = 1'b1;
			wd.start = '0;
			wd.size = AB'(pool_size_wdata);
		end else if (state_q == S_WR1) begin
			we = 1'b1;
			if (!kind_q) begin
				wa = empty_q;
				wd.start = best_e_q.start + req_q;
				wd.size = best_e_q.size - req_q;
				wd.stamp = stamp_q;
			end else begin
				wa = best_q;
				wd.start = new_start_q;
				wd.size = new_end_q - new_start_q;
				wd.stamp = stamp_q;
			end
		end else if (state_q == S_WR2) begin
			we = 1'b1;
			wa = best_q;
			wd.used = 1'b1;
			wd.start = best_e_q.start;
			wd.size = req_q;
			wd.stamp = stamp_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			valid_q <= '0;
			valid_q[0] <= 1'b1;
			pool_q <= 16'd4096;
			stamp_q <= SB'(1);
			ov_q <= 1'b0;
			rd_live_q <= 1'b0;
			rd_cnt_q <= '0;
		end else begin
			if (ov_q && !out_stall) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					// entry 0 is written by the write port this cycle
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					rd_live_q <= 1'b0;
					rd_cnt_q <= '0;
					if (pool_size_we) begin
						pool_q <= pool_size_wdata;
						valid_q <= '0;
						valid_q[0] <= (pool_size_wdata != 16'd0);
						stamp_q <= (pool_size_wdata != 16'd0) ? SB'(1) : '0;
					end else if (in_valid && !ov_q) begin
						kind_q <= kind;
						req_q <= request_size;
						addr_q <= block_address;
						best_ok_q <= 1'b0;
						empty_ok_q <= 1'b0;
						grant_q <= '0;
						if (!kind && request_size == '0) begin
							st_q <= bfa_pkg::ST_ZERO;
							state_q <= S_STAT;
						end else begin
							state_q <= S_SRCH;
						end
						rd_live_q <= 1'b1;
						rd_cnt_q <= rd_cnt_q + 1'b1;
						sf_q <= '0; lf_q <= '0; su_q <= '0; lu_q <= '0;
						fc_q <= '0; uc_q <= '0;
					end
				end
				S_SRCH: begin
					// examine one entry per cycle
					if (!rv && rd_live_q && !empty_ok_q) begin
						empty_ok_q <= 1'b1;
						empty_q <= rd_idx_d1_q;
					end
					if (rv && !kind_q && !rdata_q.used && rdata_q.size >= req_q &&
						(!best_ok_q || rdata_q.size < best_e_q.size ||
						(rdata_q.size == best_e_q.size && age_r < age_b))) begin
						best_ok_q <= 1'b1;
						best_q <= rd_idx_d1_q;
						best_e_q <= rdata_q;
					end
					if (rv && kind_q && rdata_q.used && rdata_q.start == addr_q &&
						!best_ok_q) begin
						best_ok_q <= 1'b1;
						best_q <= rd_idx_d1_q;
						best_e_q <= rdata_q;
					end
					if (rd_cnt_q[IB]) begin
						rd_live_q <= 1'b0;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (!rd_live_q) begin
						state_q <= S_DEC;
					end
					if (last_rd) begin
						rd_cnt_q <= {1'b1, {IB{1'b0}}};
					end
				end
				S_DEC: begin
					rd_cnt_q <= '0;
					if (!kind_q) begin
						if (!best_ok_q) begin
							st_q <= bfa_pkg::ST_NO_FIT;
							state_q <= S_STAT;
						end else if (best_e_q.size != req_q && !empty_ok_q) begin
							st_q <= bfa_pkg::ST_FULL;
							state_q <= S_STAT;
						end else begin
							st_q <= bfa_pkg::ST_OK;
							grant_q <= best_e_q.start;
							state_q <= (best_e_q.size != req_q) ? S_WR1 : S_WR2;
						end
					end else if (!best_ok_q) begin
						st_q <= bfa_pkg::ST_BAD_ADDR;
						state_q <= S_STAT;
					end else begin
						st_q <= bfa_pkg::ST_OK;
						bef_ok_q <= 1'b0;
						aft_ok_q <= 1'b0;
						new_start_q <= best_e_q.start;
						new_end_q <= best_e_q.start + best_e_q.size;
						state_q <= S_NBR;
					end
					if (state_q == S_DEC) begin
						rd_live_q <= 1'b1;
						rd_cnt_q <= (IB+1)'(1);
					end
				end
				S_NBR: begin
					// find free neighbours
					if (rv && !rdata_q.used) begin
						if (!bef_ok_q && rdata_q.start + rdata_q.size == best_e_q.start) begin
							bef_ok_q <= 1'b1;
							bef_q <= rd_idx_d1_q;
							new_start_q <= rdata_q.start;
						end else if (!aft_ok_q &&
							rdata_q.start == best_e_q.start + best_e_q.size) begin
							aft_ok_q <= 1'b1;
							aft_q <= rd_idx_d1_q;
							new_end_q <= rdata_q.start + rdata_q.size;
						end
					end
					if (rd_cnt_q[IB]) begin
						rd_live_q <= 1'b0;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (last_rd) begin
						rd_cnt_q <= {1'b1, {IB{1'b0}}};
					end
					if (!rd_live_q) begin
						state_q <= S_WR1;
						if (bef_ok_q) valid_q[bef_q] <= 1'b0;
						if (aft_ok_q) valid_q[aft_q] <= 1'b0;
					end
				end
				S_WR1: begin
					stamp_q <= stamp_q + 1'b1;
					if (!kind_q) begin
						valid_q[empty_q] <= 1'b1;
						state_q <= S_WR2;
					end else begin
						state_q <= S_RDH;
					end
				end
				S_WR2: begin
					stamp_q <= stamp_q + 1'b1;
					state_q <= S_RDH;
				end
				S_RDH: begin
					rd_live_q <= 1'b1;
					rd_cnt_q <= (IB+1)'(1);
					state_q <= S_STAT;
				end
				S_STAT: begin
					// accumulate statistics
					if (rv && rd_cnt_q != '0) begin
						if (rdata_q.used) begin
							if (uc_q == '0 || rdata_q.size < su_q) su_q <= rdata_q.size;
							if (rdata_q.size > lu_q) lu_q <= rdata_q.size;
							uc_q <= uc_q + 1'b1;
						end else begin
							if (fc_q == '0 || rdata_q.size < sf_q) sf_q <= rdata_q.size;
							if (rdata_q.size > lf_q) lf_q <= rdata_q.size;
							fc_q <= fc_q + 1'b1;
						end
					end
					if (rd_cnt_q == '0) begin
						rd_live_q <= 1'b1;
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end else if (rd_cnt_q[IB]) begin
						rd_live_q <= 1'b0;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (last_rd) begin
						rd_cnt_q <= {1'b1, {IB{1'b0}}};
					end
					if (!rd_live_q && rd_cnt_q[IB]) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign status = st_q;
	assign granted_address = grant_q;
	assign smallest_free = sf_q;
	assign largest_free = lf_q;
	assign free_count = fc_q;
	assign smallest_used = su_q;
	assign largest_used = lu_q;
	assign used_count = uc_q;
endmodule

// File: hdl/bfa_checker.sv
// Port-level checker for the best-fit block allocator, bound to the top.
// Depends on best_fit_block_allocator_assert.svh and bfa_pkg.
`include "best_fit_block_allocator_assert.svh"
module bfa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [15:0] granted_address,
	input logic [6:0]  free_count,
	input logic [6:0]  used_count
);
	// a failed request grants nothing
	`BFA_ASSERT_IMP(a_grant0, clk, arst_n, out_valid && status != bfa_pkg::ST_OK, granted_address == 16'd0)
	// table never over-full
	`BFA_ASSERT_IMP(a_cnt, clk, arst_n, out_valid, (free_count + used_count) <= 8'd64)
	// accepted item makes block busy
	`BFA_ASSERT_NXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// stalled result holds
	`BFA_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status))
endmodule

bind best_fit_block_allocator bfa_checker u_bfa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .status(status),
	.granted_address(granted_address), .free_count(free_count),
	.used_count(used_count)
);
